>>> hdl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define CRT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked assertion that also checks through reset
`define CRT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> hdl/crt_pkg.sv
// shared constants, codes and types of the retransmission table
package crt_pkg;

  localparam int MAX_TRANSACTIONS = 4;
  localparam int INTERVAL_BITS    = 24;
  localparam int SLOT_W = (MAX_TRANSACTIONS > 1) ? $clog2(MAX_TRANSACTIONS) : 1;

  // field widths
  localparam int ID_W    = 16;
  localparam int RND_W   = 16;
  localparam int ATT_W   = 3;
  localparam int OUTIV_W = 24;

  // operations
  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_SEND   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // events
  localparam logic [3:0] EV_OPENED    = 4'd0;
  localparam logic [3:0] EV_FULL      = 4'd1;
  localparam logic [3:0] EV_ARMED     = 4'd2;
  localparam logic [3:0] EV_FREED_NC  = 4'd3;
  localparam logic [3:0] EV_RETX      = 4'd4;
  localparam logic [3:0] EV_TIMEOUT   = 4'd5;
  localparam logic [3:0] EV_FOUND     = 4'd6;
  localparam logic [3:0] EV_NOT_FOUND = 4'd7;
  localparam logic [3:0] EV_CLEARED   = 4'd8;
  localparam logic [3:0] EV_NOTHING   = 4'd9;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_MASK    = 2'd1;
  localparam logic [1:0] CFG_MAXRETX = 2'd2;
  localparam logic [15:0]      TIMEOUT_RST = 16'd256;
  localparam logic [15:0]      MASK_RST    = 16'd128;
  localparam logic [ATT_W-1:0] MAXRETX_RST = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic div_start;
    logic step;
    logic advance;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic emits;
    logic final_step;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/crt_mod.sv
// iterative remainder unit, one quotient bit per cycle
module crt_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [crt_pkg::RND_W-1:0] dividend,
  input  logic [crt_pkg::RND_W-1:0] divisor,
  output logic                      done,
  output logic [crt_pkg::RND_W-1:0] remainder
);
  import crt_pkg::*;

  localparam int CW = $clog2(RND_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r;
  logic [RND_W-1:0] dvd_r;
  logic [RND_W-1:0] rem_r, rem_nxt;
  logic [RND_W:0]   shifted;
  logic [RND_W:0]   diff;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    shifted = {rem_r, dvd_r[RND_W-1]};
    diff    = shifted - {1'b0, divisor};
    rem_nxt = (shifted >= {1'b0, divisor}) ? diff[RND_W-1:0] : shifted[RND_W-1:0];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CW'(RND_W - 1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> hdl/crt_datapath.sv
// transaction table, configuration, per-slot update logic and result register
module crt_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  crt_pkg::cmd_t cmd,
  output crt_pkg::sts_t sts,
  input  logic [71:0]   in_tdata,
  input  logic [2:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [79:0]   out_tdata,
  output logic [3:0]    out_tuser,
  output logic          out_tlast,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import crt_pkg::*;

  localparam int N    = MAX_TRANSACTIONS;
  localparam int IW   = INTERVAL_BITS;
  localparam int SUMW = IW + 17;
  localparam logic [IW-1:0] IVL_MAX = '1;

  // configuration
  logic [15:0]      tmo_r, mask_r;
  logic [ATT_W-1:0] maxr_r;

  // latched input item
  logic [2:0]       op_r;
  logic [ID_W-1:0]  id_q_r, peer_q_r, port_q_r;
  logic [4:0]       slot_q_r;
  logic             con_r;
  logic [RND_W-1:0] rnd_r;
  logic [SLOT_W-1:0] idx_r;
  logic [N-1:0]     exp_r;
  logic             any_r;

  // table
  logic [N-1:0]     valid_r, armed_r;
  logic [ID_W-1:0]  id_r   [N];
  logic [ID_W-1:0]  peer_r [N];
  logic [ID_W-1:0]  port_r [N];
  logic [ATT_W-1:0] att_r  [N];
  logic [IW-1:0]    ivl_r  [N];
  logic [IW-1:0]    remn_r [N];

  // result register
  logic             ov_r;
  logic [3:0]       oev_r;
  logic [4:0]       oslot_r;
  logic [ID_W-1:0]  oid_r, opeer_r, oport_r;
  logic [ATT_W-1:0] oatt_r;
  logic [OUTIV_W-1:0] oivl_r;
  logic             olast_r;

  logic             div_done;
  logic [RND_W-1:0] div_rem;

  logic [N-1:0]     exp_nxt;
  logic             in_range, scan_end;
  logic             e_valid, e_armed;
  logic [ID_W-1:0]  e_id;
  logic [ATT_W-1:0] e_att, att_inc;
  logic [IW-1:0]    e_ivl, e_rem, dbl, init_iv;
  logic [SUMW-1:0]  init_sum;
  logic [N-1:0]     sel;
  logic             wr, open_wr, emits, fin, plain, last;
  logic             n_valid, n_armed;
  logic [ATT_W-1:0] n_att;
  logic [IW-1:0]    n_ivl, n_rem;
  logic [3:0]       ev;
  logic [ID_W-1:0]  plain_id;
  logic [31:0]      ivl32;
  logic             out_free;

  crt_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (rnd_r),
    .divisor   (mask_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // entries that expire on a tick, from the state before it
  always_comb begin
    for (int i = 0; i < N; i++) begin
      exp_nxt[i] = valid_r[i] && armed_r[i] && (remn_r[i] <= IW'(1));
    end
  end

  // current slot and interval arithmetic
  always_comb begin
    in_range = 6'(slot_q_r) < 6'(N);
    scan_end = idx_r == SLOT_W'(N - 1);
    e_valid  = valid_r[idx_r];
    e_armed  = armed_r[idx_r];
    e_id     = id_r[idx_r];
    e_att    = att_r[idx_r];
    e_ivl    = ivl_r[idx_r];
    e_rem    = remn_r[idx_r];
    att_inc  = (e_att == 3'd7) ? 3'd7 : e_att + 3'd1;
    dbl      = e_ivl[IW-1] ? IVL_MAX : {e_ivl[IW-2:0], 1'b0};
    init_sum = SUMW'(tmo_r) + ((mask_r != 16'd0) ? SUMW'(div_rem) : SUMW'(0));
    init_iv  = (init_sum > SUMW'(IVL_MAX)) ? IVL_MAX : init_sum[IW-1:0];
    sel        = '0;
    sel[idx_r] = 1'b1;
  end

  // per-step decision for the latched operation
  always_comb begin
    wr = 1'b0; open_wr = 1'b0; emits = 1'b0; fin = 1'b0;
    plain = 1'b1; plain_id = '0; last = 1'b1; ev = EV_NOTHING;
    n_valid = e_valid; n_armed = e_armed; n_att = e_att; n_ivl = e_ivl; n_rem = e_rem;
    case (op_r)
      OP_OPEN: begin
        if (!e_valid) begin
          emits = 1'b1; fin = 1'b1; plain = 1'b0; ev = EV_OPENED;
          wr = 1'b1; open_wr = 1'b1;
          n_valid = 1'b1; n_armed = 1'b0; n_att = '0; n_ivl = '0; n_rem = '0;
        end else if (scan_end) begin
          emits = 1'b1; fin = 1'b1; ev = EV_FULL;
        end
      end
      OP_SEND, OP_CLEAR: begin
        emits = 1'b1; fin = 1'b1;
        if (in_range && e_valid) begin
          plain = 1'b0; wr = 1'b1;
          if (op_r == OP_CLEAR) begin
            ev = EV_CLEARED; n_valid = 1'b0; n_armed = 1'b0;
          end else if (!con_r) begin
            ev = EV_FREED_NC; n_valid = 1'b0; n_armed = 1'b0;
          end else if (e_att < maxr_r) begin
            ev = EV_ARMED;
            n_ivl = (e_att == '0) ? init_iv : dbl;
            n_rem = n_ivl; n_armed = 1'b1;
          end else begin
            ev = EV_TIMEOUT; n_valid = 1'b0; n_armed = 1'b0;
          end
        end
      end
      OP_LOOKUP: begin
        if (e_valid && e_id == id_q_r) begin
          emits = 1'b1; fin = 1'b1; plain = 1'b0; ev = EV_FOUND;
        end else if (scan_end) begin
          emits = 1'b1; fin = 1'b1; ev = EV_NOT_FOUND; plain_id = id_q_r;
        end
      end
      OP_TICK: begin
        fin = scan_end;
        if (exp_r[idx_r]) begin
          emits = 1'b1; plain = 1'b0; wr = 1'b1;
          // last unless a higher slot still expires
          last  = (exp_r & ~((sel << 1) - N'(1))) == '0;
          n_rem = '0; n_att = att_inc;
          if (att_inc < maxr_r) begin
            ev = EV_RETX; n_ivl = dbl; n_rem = dbl; n_armed = 1'b1;
          end else begin
            ev = EV_TIMEOUT; n_valid = 1'b0; n_armed = 1'b0;
          end
        end else begin
          if (e_valid && e_armed) begin
            wr = 1'b1; n_rem = e_rem - IW'(1);
          end
          if (scan_end && !any_r) begin
            emits = 1'b1;
          end
        end
      end
      default: begin
        emits = 1'b1; fin = 1'b1;
      end
    endcase
    ivl32 = 32'(n_ivl);
  end

  assign out_free = !ov_r || out_tready;

  // status to the controller
  always_comb begin
    sts.need_div   = (op_r == OP_SEND) && in_range && e_valid && con_r &&
                     (e_att == '0) && (maxr_r != '0) && (mask_r != 16'd0);
    sts.div_done   = div_done;
    sts.emits      = emits;
    sts.final_step = fin;
    sts.out_free   = out_free;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r  <= TIMEOUT_RST;
      mask_r <= MASK_RST;
      maxr_r <= MAXRETX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: tmo_r  <= cfg_data;
        CFG_MASK:    mask_r <= cfg_data;
        CFG_MAXRETX: maxr_r <= cfg_data[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  // input item latch and slot index
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_tuser;
      id_q_r   <= in_tdata[15:0];
      peer_q_r <= in_tdata[31:16];
      port_q_r <= in_tdata[47:32];
      slot_q_r <= in_tdata[52:48];
      con_r    <= in_tdata[53];
      rnd_r    <= in_tdata[69:54];
      exp_r    <= exp_nxt;
      any_r    <= |exp_nxt;
      idx_r    <= (in_tuser == OP_SEND || in_tuser == OP_CLEAR) ?
                  in_tdata[48 +: SLOT_W] : '0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + SLOT_W'(1);
    end
  end

  // table flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      armed_r <= '0;
    end else if (cmd.step && wr) begin
      valid_r[idx_r] <= n_valid;
      armed_r[idx_r] <= n_armed;
    end
  end

  // table payload
  always_ff @(posedge clk) begin
    if (cmd.step && wr) begin
      att_r[idx_r]  <= n_att;
      ivl_r[idx_r]  <= n_ivl;
      remn_r[idx_r] <= n_rem;
      if (open_wr) begin
        id_r[idx_r]   <= id_q_r;
        peer_r[idx_r] <= peer_q_r;
        port_r[idx_r] <= port_q_r;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.step && emits) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  // result payload, taken after the update
  always_ff @(posedge clk) begin
    if (cmd.step && emits) begin
      oev_r   <= ev;
      olast_r <= last;
      oslot_r <= plain ? 5'd0 : 5'(idx_r);
      oid_r   <= plain ? plain_id : (open_wr ? id_q_r : e_id);
      opeer_r <= plain ? '0 : (open_wr ? peer_q_r : peer_r[idx_r]);
      oport_r <= plain ? '0 : (open_wr ? port_q_r : port_r[idx_r]);
      oatt_r  <= plain ? '0 : n_att;
      oivl_r  <= plain ? '0 : ivl32[OUTIV_W-1:0];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = oev_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {oivl_r, oatt_r, oport_r, opeer_r, oid_r, oslot_r};

endmodule

>>> hdl/crt_ctrl.sv
// sequencer: accepts an item, runs the remainder unit when a send needs it, steps through slots
module crt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  crt_pkg::sts_t sts,
  output crt_pkg::cmd_t cmd
);
  import crt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_RUN
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.emits || sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.final_step) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

>>> hdl/coap_retransmit_table.sv
// retransmission table top level: sequencer plus table datapath
// an item is latched, dispatched and then run; a first confirmable send with jitter
// also waits for the remainder unit, and open, lookup and tick visit one table slot
// per cycle unless a result is held by a stalled output, open and lookup stopping early
// a result waits in the output register; a new item is taken once the last step ends
// synchronous active-low reset frees every slot and loads the register defaults
module coap_retransmit_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // msg_id, peer_handle, peer_port, slot, confirmable, random_value
  input  logic [71:0] in_tdata,
  // operation
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_slot, result_msg_id, result_peer, result_port, attempt, interval_now
  output logic [79:0] out_tdata,
  // event_res
  output logic [3:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import crt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  crt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

>>> hdl/crt_checker.sv
// port-level checks of the retransmission table, bound to the top level
`include "assert_macros.svh"

module crt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);
  import crt_pkg::*;

  // a stalled result stays offered
  `CRT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  // no result right after reset
  `CRT_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid)
  // event codes stay in range
  `CRT_ASSERT(a_ev_range, clk, rst_n, out_tvalid |-> out_tuser <= EV_NOTHING)
  // a full table reports nothing else and ends the transaction
  `CRT_ASSERT(a_full_zero, clk, rst_n, out_tvalid && out_tuser == EV_FULL |-> out_tdata == 80'd0 && out_tlast)
  // a lookup miss names no slot, peer or port and ends the transaction
  `CRT_ASSERT(a_miss_slot, clk, rst_n, out_tvalid && out_tuser == EV_NOT_FOUND |-> out_tdata[52:0] == {32'd0, out_tdata[20:5], 5'd0} && out_tlast)

endmodule

bind coap_retransmit_table crt_checker u_crt_checker (.*);

>>> sim/crt_checker.sv
// transaction checker for the retransmission table: watches both channels and predicts results
module crt_scoreboard
  import crt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [3:0]  ev;
    logic [4:0]  slot;
    logic [15:0] id;
    logic [15:0] peer;
    logic [15:0] port;
    logic [2:0]  att;
    logic [23:0] iv;
    logic        last;
  } table_event_t;

  localparam logic [23:0] IV_SAT = 24'hFFFFFF;

  table_event_t events_due[$];

  // shadow copy of the table and its registers
  logic [15:0] sh_timeout;
  logic [15:0] sh_mask;
  logic [2:0]  sh_maxretx;
  logic        sh_valid  [MAX_TRANSACTIONS];
  logic        sh_armed  [MAX_TRANSACTIONS];
  logic [15:0] sh_id     [MAX_TRANSACTIONS];
  logic [15:0] sh_peer   [MAX_TRANSACTIONS];
  logic [15:0] sh_port   [MAX_TRANSACTIONS];
  logic [2:0]  sh_att    [MAX_TRANSACTIONS];
  logic [23:0] sh_iv     [MAX_TRANSACTIONS];
  logic [23:0] sh_remain [MAX_TRANSACTIONS];

  initial fail_count = 0;
  assign pending = events_due.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic table_event_t plain_event(input logic [3:0] ev, input logic [15:0] id);
    table_event_t e;
    e = '{ev: ev, slot: 5'd0, id: id, peer: 16'd0, port: 16'd0, att: 3'd0, iv: 24'd0,
          last: 1'b0};
    return e;
  endfunction

  function automatic table_event_t slot_event(input logic [3:0] ev, input int s);
    table_event_t e;
    e = '{ev: ev, slot: s[4:0], id: sh_id[s], peer: sh_peer[s], port: sh_port[s],
          att: sh_att[s], iv: sh_iv[s], last: 1'b0};
    return e;
  endfunction

  // confirmable arm step: returns 1 when the entry was armed, 0 on timeout
  function automatic logic arm_entry(input int s, input logic [15:0] rnd);
    logic [24:0] next_iv;
    if (sh_att[s] >= sh_maxretx) return 1'b0;
    if (sh_att[s] == 3'd0) begin
      next_iv = {9'd0, sh_timeout};
      if (sh_mask != 16'd0) next_iv = next_iv + 25'(rnd % sh_mask);
    end else begin
      next_iv = {sh_iv[s], 1'b0};
    end
    if (next_iv > {1'b0, IV_SAT}) next_iv = {1'b0, IV_SAT};
    sh_iv[s]     = next_iv[23:0];
    sh_remain[s] = next_iv[23:0];
    sh_armed[s]  = 1'b1;
    return 1'b1;
  endfunction

  task automatic predict_item(input logic [2:0] op, input logic [71:0] d);
    logic [15:0] id, peer, port, rnd;
    logic [4:0]  s;
    logic        con;
    int          hit;
    table_event_t batch[$];
    id   = d[15:0];
    peer = d[31:16];
    port = d[47:32];
    s    = d[52:48];
    con  = d[53];
    rnd  = d[69:54];
    hit  = -1;
    case (op)
      OP_OPEN: begin
        for (int i = MAX_TRANSACTIONS - 1; i >= 0; i--) if (!sh_valid[i]) hit = i;
        if (hit < 0) begin
          batch.push_back(plain_event(EV_FULL, 16'd0));
        end else begin
          sh_valid[hit] = 1'b1;
          sh_armed[hit] = 1'b0;
          sh_id[hit] = id;
          sh_peer[hit] = peer;
          sh_port[hit] = port;
          sh_att[hit] = 3'd0;
          sh_iv[hit] = 24'd0;
          sh_remain[hit] = 24'd0;
          batch.push_back(slot_event(EV_OPENED, hit));
        end
      end
      OP_SEND, OP_CLEAR: begin
        if (s >= MAX_TRANSACTIONS || !sh_valid[s]) begin
          batch.push_back(plain_event(EV_NOTHING, 16'd0));
        end else if (op == OP_CLEAR) begin
          batch.push_back(slot_event(EV_CLEARED, s));
          sh_valid[s] = 1'b0;
          sh_armed[s] = 1'b0;
        end else if (!con) begin
          batch.push_back(slot_event(EV_FREED_NC, s));
          sh_valid[s] = 1'b0;
          sh_armed[s] = 1'b0;
        end else if (arm_entry(s, rnd)) begin
          batch.push_back(slot_event(EV_ARMED, s));
        end else begin
          batch.push_back(slot_event(EV_TIMEOUT, s));
          sh_valid[s] = 1'b0;
          sh_armed[s] = 1'b0;
        end
      end
      OP_LOOKUP: begin
        for (int i = MAX_TRANSACTIONS - 1; i >= 0; i--)
          if (sh_valid[i] && sh_id[i] == id) hit = i;
        if (hit < 0) batch.push_back(plain_event(EV_NOT_FOUND, id));
        else batch.push_back(slot_event(EV_FOUND, hit));
      end
      OP_TICK: begin
        // countdown in slot order, one event per expiry
        for (int i = 0; i < MAX_TRANSACTIONS; i++) begin
          if (sh_valid[i] && sh_armed[i]) begin
            if (sh_remain[i] > 24'd1) begin
              sh_remain[i]--;
            end else begin
              sh_remain[i] = 24'd0;
              if (sh_att[i] < 3'd7) sh_att[i]++;
              if (arm_entry(i, rnd)) begin
                batch.push_back(slot_event(EV_RETX, i));
              end else begin
                batch.push_back(slot_event(EV_TIMEOUT, i));
                sh_valid[i] = 1'b0;
                sh_armed[i] = 1'b0;
              end
            end
          end
        end
        if (batch.size() == 0) batch.push_back(plain_event(EV_NOTHING, 16'd0));
      end
      default: batch.push_back(plain_event(EV_NOTHING, 16'd0));
    endcase
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) events_due.push_back(batch[k]);
  endtask

  // watch configuration, input and output transactions
  always @(posedge clk) begin
    table_event_t e;
    if (!rst_n) begin
      sh_timeout = TIMEOUT_RST;
      sh_mask    = MASK_RST;
      sh_maxretx = MAXRETX_RST;
      for (int i = 0; i < MAX_TRANSACTIONS; i++) begin
        sh_valid[i] = 1'b0;
        sh_armed[i] = 1'b0;
      end
      events_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: sh_timeout = cfg_data;
          CFG_MASK:    sh_mask = cfg_data;
          CFG_MAXRETX: sh_maxretx = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (events_due.size() == 0) begin
          report("unexpected result", out_tuser, 0);
        end else begin
          e = events_due.pop_front();
          if (out_tuser !== e.ev) report("event", out_tuser, e.ev);
          if (out_tdata[4:0] !== e.slot) report("slot", out_tdata[4:0], e.slot);
          if (out_tdata[20:5] !== e.id) report("msg id", out_tdata[20:5], e.id);
          if (out_tdata[36:21] !== e.peer) report("peer", out_tdata[36:21], e.peer);
          if (out_tdata[52:37] !== e.port) report("port", out_tdata[52:37], e.port);
          if (out_tdata[55:53] !== e.att) report("attempt", out_tdata[55:53], e.att);
          if (out_tdata[79:56] !== e.iv) report("interval", out_tdata[79:56], e.iv);
          if (out_tlast !== e.last) report("last", out_tlast, e.last);
        end
      end
    end
  end

endmodule

>>> sim/testbench.sv
// testbench top: clock, reset, stimulus and verdict for the retransmission table
module testbench;
  import crt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // msg_id, peer_handle, peer_port, slot, confirmable, random_value
  logic [71:0] in_tdata;
  // operation
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // result_slot, result_msg_id, result_peer, result_port, attempt, interval_now
  logic [79:0] out_tdata;
  // event_res
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count;
  logic [15:0] id_pool [4];

  coap_retransmit_table i_dut (.*);

  crt_scoreboard i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic push_item(input logic [2:0] op, input logic [15:0] id, input logic [15:0] peer,
                           input logic [15:0] port, input logic [4:0] s, input logic con,
                           input logic [15:0] rnd);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, rnd, con, s, port, peer, id};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // hold off until every result is in, let the block settle, then write registers
  task automatic write_regs(input logic [15:0] tmo, input logic [15:0] mask,
                            input logic [2:0] maxr);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_TIMEOUT; cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= CFG_MASK; cfg_data <= mask;
    @(posedge clk);
    cfg_index <= CFG_MAXRETX; cfg_data <= {13'd0, maxr};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed traffic on a small id pool so lookups hit and timers expire
  task automatic random_phase(input int count);
    int          pick;
    logic [2:0]  op;
    logic [15:0] id;
    logic [4:0]  s;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      id   = ($urandom_range(3) == 0) ? 16'($urandom) : id_pool[$urandom_range(3)];
      s    = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(3));
      if (pick < 18) op = OP_OPEN;
      else if (pick < 42) op = OP_SEND;
      else if (pick < 50) op = OP_CLEAR;
      else if (pick < 62) op = OP_LOOKUP;
      else if (pick < 95) op = OP_TICK;
      else op = 3'($urandom_range(7, 5));
      push_item(op, id, 16'($urandom), 16'($urandom), s, ($urandom_range(9) != 0),
                16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    send_idle_pct = 20;
    recv_idle_pct = 47;
    foreach (id_pool[k]) id_pool[k] = 16'($urandom);
    id_pool[0] = 16'hFFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset defaults
    push_item(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1, 16'hFFFF);
    push_item(OP_TICK, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0, 16'h0);
    push_item(OP_LOOKUP, 16'hFFFF, 16'h0, 16'h0, 5'd0, 1'b0, 16'h0);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd31, 1'b1, 16'h0);
    push_item(OP_CLEAR, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0, 16'h0);
    push_item(OP_OPEN, 16'h0000, 16'h0000, 16'h0000, 5'd31, 1'b0, 16'h0);
    push_item(OP_OPEN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd0, 1'b1, 16'hFFFF);
    push_item(OP_OPEN, 16'h1234, 16'hA5A5, 16'h5A5A, 5'd0, 1'b0, 16'h0);
    push_item(OP_OPEN, 16'h8001, 16'h7FFE, 16'h0001, 5'd0, 1'b0, 16'h0);
    push_item(OP_OPEN, 16'h4321, 16'h1111, 16'h2222, 5'd0, 1'b0, 16'h0);
    push_item(OP_LOOKUP, 16'h8001, 16'h0, 16'h0, 5'd0, 1'b0, 16'h0);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd1, 1'b0, 16'h0);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd0, 1'b1, 16'hFFFF);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd0, 1'b1, 16'h0007);
    push_item(OP_CLEAR, 16'h0, 16'h0, 16'h0, 5'd2, 1'b0, 16'h0);
    push_item(OP_TICK, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0, 16'h0);

    // zero interval, no jitter: armed entries expire on every tick until attempts saturate and they time out
    write_regs(16'd0, 16'd0, 3'd7);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd0, 1'b1, 16'h0);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd3, 1'b1, 16'h0);
    repeat (8) push_item(OP_TICK, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0, 16'hFFFF);
    random_phase(50);

    // short timers with jitter
    write_regs(16'd2, 16'd3, 3'd3);
    random_phase(45);

    // receiver now idles more rarely than the sender
    send_idle_pct = 47;
    recv_idle_pct = 20;
    write_regs(16'd1, 16'd1, 3'd0);
    random_phase(20);
    write_regs(16'hFFFF, 16'hFFFF, 3'd2);
    push_item(OP_OPEN, 16'hBEEF, 16'h0, 16'h0, 5'd0, 1'b0, 16'h0);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd0, 1'b1, 16'hFFFE);
    push_item(OP_SEND, 16'h0, 16'h0, 16'h0, 5'd1, 1'b1, 16'hFFFF);
    random_phase(15);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(16'd1, 16'd2, 3'd4);
    random_phase(25);

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
